// ===== src/mcf_pkg.sv =====
package mcf_pkg;

  localparam int DIV_W  = 24;
  localparam int DVSR_W = 16;
  localparam int CNT_W  = 5;

  localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;
  localparam logic [15:0] CAL_SAMPLES_RESET = 16'd3000;

  localparam logic signed [17:0] OFFSET_RESET_X = -18'sd12;
  localparam logic signed [17:0] OFFSET_RESET_Y = 18'sd70;
  localparam logic signed [17:0] OFFSET_RESET_Z = -18'sd106;
  localparam logic [23:0] SCALE_RESET_X = 24'd107546;
  localparam logic [23:0] SCALE_RESET_Y = 24'd699051;
  localparam logic [23:0] SCALE_RESET_Z = 24'd102300;

  typedef struct packed {
    logic       in_load;
    logic       cal_update;
    logic       div_start;
    logic       div_avg;
    logic       scale_load;
    logic       mul;
    logic       rnd;
    logic       sum;
    logic       field_load;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic cal_finish;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/mcf_divider.sv =====
module mcf_divider
  import mcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  logic [CNT_W-1:0]  count;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W:0]   trial;
  logic              fits;

  assign trial    = {rem, quotient[DIV_W-1]};
  assign fits     = trial >= {1'b0, divisor};

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(DIV_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (count != '0) begin
      rem      <= fits ? DVSR_W'(trial - {1'b0, divisor}) : trial[DVSR_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

// ===== src/mcf_controller.sv =====
module mcf_controller
  import mcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CAL   = 4'd1;
  localparam logic [3:0] ST_SDIV  = 4'd2;
  localparam logic [3:0] ST_SWAIT = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_RND   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_AVG   = 4'd7;
  localparam logic [3:0] ST_AWAIT = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;

  assign in_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_CAL;
        end
      end
      ST_CAL: begin
        cmd.cal_update = 1'b1;
        axis_next      = 2'd0;
        state_next     = sts.cal_finish ? ST_SDIV : ST_MUL;
      end
      ST_SDIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sts.div_done) begin
          cmd.scale_load = 1'b1;
          if (axis == 2'd2) begin
            axis_next  = 2'd0;
            state_next = ST_MUL;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = ST_SDIV;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_AVG;
      end
      ST_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_next    = ST_AWAIT;
      end
      ST_AWAIT: begin
        cmd.div_avg = 1'b1;
        if (sts.div_done) begin
          cmd.field_load = 1'b1;
          if (axis == 2'd2) begin
            state_next = ST_OUT;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

// ===== src/mcf_datapath.sv =====
module mcf_datapath
  import mcf_pkg::*;
#(
  parameter int WINDOW_LENGTH = 8
)
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [15:0]        calibration_samples,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  logic               start_calibration,
  input  logic               out_taken,
  output logic               out_valid,
  output logic signed [15:0] field_x,
  output logic signed [15:0] field_y,
  output logic signed [15:0] field_z,
  output logic               calibrating,
  output logic               calibration_done
);

  localparam int PW = $clog2(WINDOW_LENGTH);
  localparam int AW = $clog2(3 * WINDOW_LENGTH);
  localparam int SW = 17 + PW;

  logic signed [15:0] raw [3];
  logic               start_r;
  logic               cal_active;
  logic [15:0]        cal_count;
  logic               done_r;
  logic signed [15:0] axis_max [3];
  logic signed [15:0] axis_min [3];
  logic signed [17:0] axis_offset [3];
  logic [23:0]        axis_scale [3];
  logic signed [SW-1:0] window_sum [3];
  logic [PW-1:0]      window_pos;
  logic               window_full;
  logic signed [15:0] window_store [3*WINDOW_LENGTH];
  logic signed [15:0] old_entry;
  logic signed [43:0] prod;
  logic signed [15:0] corr;
  logic signed [15:0] field [3];

  logic               act;
  logic [15:0]        cnt_inc;
  logic               finish;
  logic signed [15:0] max_new [3];
  logic signed [15:0] min_new [3];

  logic [AW-1:0]      addr;
  logic signed [16:0] span;
  logic               span_zero;
  logic signed [18:0] diff;
  logic signed [24:0] scale_s;
  logic [43:0]        prod_mag;
  logic [34:0]        prod_q;
  logic signed [15:0] corr_next;
  logic signed [SW-1:0] sum_next;
  logic [PW:0]        fill;
  logic [SW-1:0]      sum_mag;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVSR_W-1:0]  div_divisor;
  logic [DIV_W-1:0]   div_quotient;
  logic               div_done;
  logic [15:0]        avg_q;

  // calibration run bookkeeping
  assign act     = cal_active | start_r;
  assign cnt_inc = (start_r ? 16'd0 : cal_count) + 16'd1;
  assign finish  = act && (cnt_inc >= calibration_samples);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      max_new[k] = (raw[k] > axis_max[k]) ? raw[k] : axis_max[k];
      min_new[k] = (raw[k] < axis_min[k]) ? raw[k] : axis_min[k];
    end
  end

  assign addr = AW'(cmd.axis) * AW'(WINDOW_LENGTH) + AW'(window_pos);

  assign span      = 17'(axis_max[cmd.axis]) - 17'(axis_min[cmd.axis]);
  assign span_zero = (span == 17'sd0) || span[16];

  assign diff    = {{2{raw[cmd.axis][15]}}, raw[cmd.axis], 1'b0}
                 - 19'(axis_offset[cmd.axis]);
  assign scale_s = $signed({1'b0, axis_scale[cmd.axis]});

  assign prod_mag = prod[43] ? 44'(-prod) : 44'(prod);
  assign prod_q   = 35'((prod_mag + 44'd256) >> 9);

  always_comb begin
    if (prod[43]) begin
      corr_next = (prod_q > 35'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, prod_q}));
    end else begin
      corr_next = (prod_q > 35'd32767) ? 16'sd32767 : $signed(prod_q[15:0]);
    end
  end

  assign sum_next = window_sum[cmd.axis]
                  - (window_full ? SW'(old_entry) : SW'(0)) + SW'(corr);

  assign fill    = window_full ? (PW+1)'(WINDOW_LENGTH) : (PW+1)'(window_pos) + 1'b1;
  assign sum_mag = window_sum[cmd.axis][SW-1] ? SW'(-window_sum[cmd.axis])
                                              : SW'(window_sum[cmd.axis]);

  always_comb begin
    if (cmd.div_avg) begin
      div_dividend = DIV_W'(sum_mag) + DIV_W'(fill >> 1);
      div_divisor  = DVSR_W'(fill);
    end else begin
      div_dividend = DIV_W'(24'h800000) + DIV_W'(span[15:1]);
      div_divisor  = span[15:0];
    end
  end

  assign avg_q = div_quotient[15:0];

  mcf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign sts.cal_finish = finish;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_taken;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      raw[0]  <= raw_x;
      raw[1]  <= raw_y;
      raw[2]  <= raw_z;
      start_r <= start_calibration;
    end
    if (cmd.mul) begin
      prod      <= diff * scale_s;
      old_entry <= window_store[addr];
    end
    if (cmd.rnd) begin
      corr <= corr_next;
    end
    if (cmd.sum) begin
      window_store[addr] <= corr;
    end
    if (cmd.field_load) begin
      field[cmd.axis] <= window_sum[cmd.axis][SW-1] ? 16'(-avg_q) : avg_q;
    end
    if (cmd.out_load) begin
      field_x          <= field[0];
      field_y          <= field[1];
      field_z          <= field[2];
      calibrating      <= cal_active;
      calibration_done <= done_r;
    end
  end

  // state that the model resets
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_active     <= 1'b0;
      cal_count      <= 16'd0;
      done_r         <= 1'b0;
      axis_offset[0] <= OFFSET_RESET_X;
      axis_offset[1] <= OFFSET_RESET_Y;
      axis_offset[2] <= OFFSET_RESET_Z;
      axis_scale[0]  <= SCALE_RESET_X;
      axis_scale[1]  <= SCALE_RESET_Y;
      axis_scale[2]  <= SCALE_RESET_Z;
      for (int k = 0; k < 3; k++) begin
        axis_max[k]   <= -16'sd32768;
        axis_min[k]   <= 16'sd32767;
        window_sum[k] <= '0;
      end
      window_pos  <= '0;
      window_full <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.cal_update) begin
        done_r <= finish;
        if (act) begin
          cal_active <= !finish;
          cal_count  <= finish ? 16'd0 : cnt_inc;
          for (int k = 0; k < 3; k++) begin
            axis_max[k] <= max_new[k];
            axis_min[k] <= min_new[k];
            if (finish) begin
              axis_offset[k] <= 18'(max_new[k]) + 18'(min_new[k]);
            end
          end
        end
      end
      if (cmd.scale_load) begin
        axis_scale[cmd.axis] <= span_zero ? SCALE_MAX : div_quotient[23:0];
      end
      if (cmd.sum) begin
        window_sum[cmd.axis] <= sum_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (window_pos == PW'(WINDOW_LENGTH - 1)) begin
          window_pos  <= '0;
          window_full <= 1'b1;
        end else begin
          window_pos <= window_pos + 1'b1;
        end
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/magnetometer_calibrate_filter_unit.sv =====
// Magnetometer calibration and smoothing. Each transfer on the slave stream
// carries one raw three-axis sample; a 1 on start_calibration opens a run of
// calibration_samples samples that widens the per-axis max/min (never cleared
// between runs). The last sample of a run sets offset = max+min (half-LSB)
// and scale = 2/(max-min) in Q2.22, saturating when the span is zero, and is
// itself corrected with the new values. Every sample is corrected, rounded and
// saturated to Q2.14, then averaged over a window of WINDOW_LENGTH entries per
// axis (divided by the fill count until the window is full). Exactly one
// result transfer leaves per sample. One sample is worked at a time; the
// shared 24-step serial divider works the three averages of every sample and
// the three scales on the sample that ends a run. The next sample is taken
// while a finished result still waits on the master side.
module magnetometer_calibrate_filter_unit
  import mcf_pkg::*;
#(
  parameter int WINDOW_LENGTH = 8
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
  input  logic [0:0]  s_tuser,   // start_calibration
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // field_x, field_y, field_z
  output logic [1:0]  m_tuser,   // calibrating, calibration_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]        calibration_samples;
  cmd_t               cmd;
  sts_t               sts;
  logic signed [15:0] field_x, field_y, field_z;
  logic               calibrating, calibration_done;

  // register file: one register at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, calibration_samples} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_samples <= CAL_SAMPLES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      calibration_samples <= pwdata[15:0];
    end
  end

  mcf_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_tvalid),
    .in_tready (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcf_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .calibration_samples (calibration_samples),
    .raw_x               (s_tdata[15:0]),
    .raw_y               (s_tdata[31:16]),
    .raw_z               (s_tdata[47:32]),
    .start_calibration   (s_tuser[0]),
    .out_taken           (m_tvalid && m_tready),
    .out_valid           (m_tvalid),
    .field_x             (field_x),
    .field_y             (field_y),
    .field_z             (field_z),
    .calibrating         (calibrating),
    .calibration_done    (calibration_done)
  );

  // pack the result transfer
  assign m_tdata = {field_z, field_y, field_x};
  assign m_tuser = {calibration_done, calibrating};

`ifndef SYNTHESIS
  // a run that has just finished is no longer in progress
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && m_tuser[0]))
    else $error("calibration_done with calibrating still set");

  // hold off the next sample while one is being worked
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while busy");

  // a register write reads back
  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == 1'b0) |=>
      (paddr[2] != 1'b0 || prdata[15:0] == $past(pwdata[15:0])))
    else $error("calibration_samples readback mismatch");
`endif

endmodule
